### hw/rtl/lzom_pkg.sv
// Shared widths, command codes and status codes for the layer z-order manager.
`timescale 1ns / 1ps

package lzom_pkg;

  localparam int MODE_W = 2;
  localparam int LIDX_W = 4;
  localparam int TGT_W  = 6;
  localparam int STAT_W = 2;
  localparam int DEP_W  = 5;

  typedef enum logic [MODE_W-1:0] {
    MODE_ALLOC = 2'd0,
    MODE_SET   = 2'd1,
    MODE_FREE  = 2'd2,
    MODE_NOP   = 2'd3
  } mode_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_UNALLOC = 2'd2
  } status_t;

endpackage

### hw/rtl/lzom_if.sv
// Command and response channel interfaces for the layer z-order manager.
`timescale 1ns / 1ps

interface lzom_cmd_if
  import lzom_pkg::*;
  ();
  logic                     valid;
  logic                     ready;
  logic [MODE_W-1:0]        mode;
  logic [LIDX_W-1:0]        layer_index;
  logic signed [TGT_W-1:0]  target_depth;

  modport source (output valid, mode, layer_index, target_depth, input ready);
  modport sink   (input valid, mode, layer_index, target_depth, output ready);
endinterface

interface lzom_rsp_if
  import lzom_pkg::*;
  ();
  logic                     valid;
  logic                     ready;
  logic [STAT_W-1:0]        status;
  logic [LIDX_W-1:0]        layer_out;
  logic signed [DEP_W-1:0]  depth_out;
  logic signed [DEP_W-1:0]  top_out;

  modport source (output valid, status, layer_out, depth_out, top_out, input ready);
  modport sink   (input valid, status, layer_out, depth_out, top_out, output ready);
endinterface

### hw/rtl/lzom_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
`timescale 1ns / 1ps

module lzom_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### hw/rtl/layer_z_order_manager_unit.sv
// Top level of the layer z-order manager: command sequencer, layer tables, response register.
`timescale 1ns / 1ps

// Layer z-order manager.
// cmd channel: one item per command (allocate, set depth, free, no-op).
// rsp channel: exactly one item per command: status, layer, its depth, top depth.
// One command is in flight at a time; cmd.ready is high only while the
// sequencer is idle.
// Sequencing after a command is accepted:
//   no-op, errors, free of a hidden layer: respond straight after the depth read.
//   allocate   : a one-layer-a-cycle scan for the lowest free layer, ending
//                with a full status when the pool is full.
//   set / free : read depth, clamp, plan; when something moves, shift the
//                stack entries in between, then place the layer. The shift
//                loop runs through the stack RAM, one read and one write per
//                cycle.
// The response sits in an output register; the next command is taken while
// it waits, and its own result waits in the sequencer until the receiver
// drains the register, so a stalled receiver stalls at most one command.
// Reset (rst, synchronous): all layers free, top depth -1, nothing visible.
// The order stack and depth RAM need no clearing: free layers read depth -1
// through their in-use flags, and only written stack slots are ever read.
module layer_z_order_manager_unit
  import lzom_pkg::*;
#(
  parameter int LAYERS = 16
) (
  input  logic       clk,
  input  logic       rst,
  lzom_cmd_if.sink   cmd,
  lzom_rsp_if.source rsp
);

  localparam int LW  = $clog2(LAYERS);              // layer index / stack address
  localparam int DW  = LW + 2;                      // signed depth, -1..LAYERS
  localparam int IXW = ((LW > LIDX_W) ? LW : LIDX_W) + 1;
  localparam int CW  = ((DW > TGT_W) ? DW : TGT_W) + 1;
  localparam int XW  = (DW > DEP_W) ? DW : DEP_W;
  localparam logic signed [DW-1:0] NEG1 = DW'(-1);

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_SCAN  = 8'b0000_0010,
    S_RDDEP = 8'b0000_0100,
    S_CLAMP = 8'b0000_1000,
    S_PLAN  = 8'b0001_0000,
    S_SHIFT = 8'b0010_0000,
    S_PLACE = 8'b0100_0000,
    S_DONE  = 8'b1000_0000
  } state_t;

  state_t state;

  // layer tables
  logic [LAYERS-1:0]       in_use;
  logic signed [DW-1:0]    top;

  // latched command
  mode_t                   cmd_mode;
  logic [LIDX_W-1:0]       cmd_layer;
  logic signed [TGT_W-1:0] cmd_tgt;
  logic [LW-1:0]           lyr;
  logic                    lyr_ok;

  // move plan
  logic signed [DW-1:0]    old_d;
  logic signed [DW-1:0]    nz;
  logic                    ins;        // hidden layer becomes visible
  logic                    hide;       // visible layer becomes hidden
  logic                    desc;       // stack entries move one slot up
  logic signed [DW-1:0]    src;
  logic [LW:0]             cnt;
  logic                    rd_pend;
  logic signed [DW-1:0]    rd_src;
  logic [LW-1:0]           scan_i;

  // pending result
  status_t                 res_status;
  logic [LIDX_W-1:0]       res_layer;
  logic signed [DW-1:0]    res_depth;

  // response register
  logic                    out_v;
  logic [STAT_W-1:0]       out_status;
  logic [LIDX_W-1:0]       out_layer;
  logic signed [DEP_W-1:0] out_depth;
  logic signed [DEP_W-1:0] out_top;

  // RAM ports
  logic                    stk_we;
  logic [LW-1:0]           stk_waddr;
  logic [LW-1:0]           stk_wdata;
  logic [LW-1:0]           stk_raddr;
  logic [LW-1:0]           stk_q;
  logic                    dep_we;
  logic [LW-1:0]           dep_waddr;
  logic [DW-1:0]           dep_wdata;
  logic [LW-1:0]           dep_raddr;
  logic [DW-1:0]           dep_q;

  // combinational helpers
  logic [IXW-1:0]          lay_in_x;
  logic                    lay_in_ok;
  logic [IXW-1:0]          scan_x;
  logic                    old_vis;
  logic signed [CW-1:0]    tgt_x;
  logic signed [CW-1:0]    top_x;
  logic signed [CW-1:0]    hi_x;
  logic signed [CW-1:0]    nz_x;
  logic signed [DW-1:0]    old_rd;
  logic signed [DW-1:0]    wr_dst;
  logic signed [DW-1:0]    cnt_s;
  logic signed [DW-1:0]    src_s;
  logic signed [XW-1:0]    res_depth_x;
  logic signed [XW-1:0]    top_xo;
  logic                    out_free;

  lzom_ram #(.WIDTH(LW), .DEPTH(LAYERS)) u_stack (
    .clk   (clk),
    .we    (stk_we),
    .waddr (stk_waddr),
    .wdata (stk_wdata),
    .raddr (stk_raddr),
    .rdata (stk_q)
  );

  lzom_ram #(.WIDTH(DW), .DEPTH(LAYERS)) u_depth (
    .clk   (clk),
    .we    (dep_we),
    .waddr (dep_waddr),
    .wdata (dep_wdata),
    .raddr (dep_raddr),
    .rdata (dep_q)
  );

  assign lay_in_x  = IXW'(cmd.layer_index);
  assign lay_in_ok = lay_in_x < IXW'(LAYERS);
  assign scan_x    = IXW'(scan_i);

  // free layers read as hidden
  assign old_rd  = in_use[lyr] ? $signed(dep_q) : NEG1;
  assign old_vis = !old_d[DW-1];

  // clamp to -1..top (visible) or -1..top+1 (hidden)
  assign tgt_x = CW'(cmd_tgt);
  assign top_x = CW'(top);
  assign hi_x  = old_vis ? top_x : top_x + CW'(1);
  always_comb begin
    nz_x = (tgt_x > hi_x) ? hi_x : tgt_x;
    if (nz_x < CW'(-1)) begin
      nz_x = CW'(-1);
    end
  end

  // shift plan: desc moves src -> src+1 walking down, else src -> src-1 walking up
  always_comb begin
    if (old_d[DW-1]) begin
      src_s = top;
      cnt_s = top - nz + DW'(1);
    end else if (old_d > nz && !nz[DW-1]) begin
      src_s = old_d - DW'(1);
      cnt_s = old_d - nz;
    end else if (nz[DW-1]) begin
      src_s = old_d + DW'(1);
      cnt_s = top - old_d;
    end else begin
      src_s = old_d + DW'(1);
      cnt_s = nz - old_d;
    end
  end

  assign wr_dst   = desc ? rd_src + DW'(1) : rd_src - DW'(1);
  assign out_free = !out_v || rsp.ready;

  // RAM port steering
  always_comb begin
    stk_we    = 1'b0;
    stk_waddr = src[LW-1:0];
    stk_wdata = stk_q;
    stk_raddr = src[LW-1:0];
    dep_we    = 1'b0;
    dep_waddr = lyr;
    dep_wdata = NEG1;
    dep_raddr = lay_in_x[LW-1:0];
    case (state)
      S_SCAN: begin
        dep_waddr = scan_i;
        dep_we    = !in_use[scan_i];      // new layer starts hidden
      end
      S_SHIFT: begin
        if (rd_pend) begin
          stk_we    = 1'b1;
          stk_waddr = wr_dst[LW-1:0];
          dep_we    = 1'b1;
          dep_waddr = stk_q;
          dep_wdata = wr_dst;
        end
      end
      S_PLACE: begin
        dep_we = 1'b1;
        if (!hide) begin
          stk_we    = 1'b1;
          stk_waddr = nz[LW-1:0];
          stk_wdata = lyr;
          dep_wdata = nz;
        end
      end
      default: begin
      end
    endcase
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      in_use  <= '0;
      top     <= NEG1;
      rd_pend <= 1'b0;
      cnt     <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (cmd.valid) begin
            cmd_mode  <= mode_t'(cmd.mode);
            cmd_layer <= cmd.layer_index;
            cmd_tgt   <= cmd.target_depth;
            lyr       <= lay_in_x[LW-1:0];
            lyr_ok    <= lay_in_ok;
            scan_i    <= '0;
            state     <= (mode_t'(cmd.mode) == MODE_ALLOC) ? S_SCAN : S_RDDEP;
          end
        end
        S_SCAN: begin
          res_depth <= NEG1;
          if (!in_use[scan_i]) begin
            in_use[scan_i] <= 1'b1;
            res_status     <= ST_OK;
            res_layer      <= scan_x[LIDX_W-1:0];
            state          <= S_DONE;
          end else if (scan_i == LW'(LAYERS - 1)) begin
            res_status <= ST_FULL;
            res_layer  <= '0;
            state      <= S_DONE;
          end else begin
            scan_i <= scan_i + LW'(1);
          end
        end
        S_RDDEP: begin
          old_d      <= old_rd;
          res_layer  <= cmd_layer;
          res_status <= ST_OK;
          res_depth  <= NEG1;
          if (cmd_mode == MODE_NOP) begin
            if (lyr_ok) begin
              res_depth <= old_rd;
            end
            state <= S_DONE;
          end else if (!lyr_ok || !in_use[lyr]) begin
            res_status <= ST_UNALLOC;
            state      <= S_DONE;
          end else if (cmd_mode == MODE_FREE && old_rd[DW-1]) begin
            in_use[lyr] <= 1'b0;
            state       <= S_DONE;
          end else begin
            state <= S_CLAMP;
          end
        end
        S_CLAMP: begin
          nz    <= (cmd_mode == MODE_FREE) ? NEG1 : nz_x[DW-1:0];
          state <= S_PLAN;
        end
        S_PLAN: begin
          ins       <= old_d[DW-1];
          hide      <= old_vis && nz[DW-1];
          desc      <= old_d[DW-1] || (old_d > nz && !nz[DW-1]);
          src       <= src_s;
          cnt       <= '0;
          rd_pend   <= 1'b0;
          res_depth <= old_d;
          if (nz == old_d || (old_d[DW-1] && top >= DW'(LAYERS - 1))) begin
            state <= S_DONE;
          end else if (cnt_s == '0) begin
            state <= S_PLACE;
          end else begin
            cnt   <= cnt_s[LW:0];
            state <= S_SHIFT;
          end
        end
        S_SHIFT: begin
          rd_src <= src;
          if (cnt != '0) begin
            src     <= desc ? src - DW'(1) : src + DW'(1);
            cnt     <= cnt - (LW + 1)'(1);
            rd_pend <= 1'b1;
          end else begin
            rd_pend <= 1'b0;
            if (!rd_pend) begin
              state <= S_PLACE;
            end
          end
        end
        S_PLACE: begin
          if (hide) begin
            top       <= top - DW'(1);
            res_depth <= NEG1;
          end else begin
            res_depth <= nz;
            if (ins) begin
              top <= top + DW'(1);
            end
          end
          if (cmd_mode == MODE_FREE) begin
            in_use[lyr] <= 1'b0;
            res_depth   <= NEG1;
          end
          state <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // response register
  assign res_depth_x = XW'(res_depth);
  assign top_xo      = XW'(top);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_v <= 1'b0;
    end else if (state == S_DONE && out_free) begin
      out_v <= 1'b1;
    end else if (rsp.ready) begin
      out_v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && out_free) begin
      out_status <= res_status;
      out_layer  <= res_layer;
      out_depth  <= res_depth_x[DEP_W-1:0];
      out_top    <= top_xo[DEP_W-1:0];
    end
  end

  assign cmd.ready     = (state == S_IDLE);
  assign rsp.valid     = out_v;
  assign rsp.status    = out_status;
  assign rsp.layer_out = out_layer;
  assign rsp.depth_out = out_depth;
  assign rsp.top_out   = out_top;

`ifndef ASSERT_OFF
  // a response appears only when the sequencer hands one over
  a_rsp_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_v) |-> $past(state == S_DONE))
    else $error("response loaded outside done state");

  // no stack move is left over when a new command is taken
  a_idle_clean: assert property (@(posedge clk) disable iff (rst)
    cmd.ready |-> (!rd_pend && cnt == '0))
    else $error("command accepted with shift in progress");

  // shift reads stay inside the stack
  a_shift_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_SHIFT && cnt != '0) |-> (!src[DW-1] && src < DW'(LAYERS)))
    else $error("stack read out of range");

  // inserting a hidden layer grows the visible stack by one
  a_insert_top: assert property (@(posedge clk) disable iff (rst)
    (state == S_PLACE && ins && !hide) |=> (top == $past(top) + DW'(1)))
    else $error("top depth not advanced on insert");
`endif

endmodule

### tb/tb.sv
// Self-checking testbench for the layer z-order manager: predictor, scoreboard, drivers.
`timescale 1ns / 1ps

module tb;
  import lzom_pkg::*;

  localparam int LAYERS    = 16;
  localparam int CYC_LIMIT = 400000;  // far above the slowest legal run
  localparam int N_RANDOM  = 1800;
  localparam int DRAIN_CYC = LAYERS + 16;  // longer than the worst command latency
  localparam int MAX_SHOWN = 10;

  // one expected response item
  typedef struct packed {
    logic [STAT_W-1:0]       status;
    logic [LIDX_W-1:0]       layer;
    logic signed [DEP_W-1:0] depth;
    logic signed [DEP_W-1:0] top;
  } rsp_item_t;

  // Tracks the layer pool and stacking order, predicts each response and
  // checks the responses in order against what it predicted.
  class zorder_tracker;
    bit        in_use[LAYERS];
    int        depth_of[LAYERS];
    int        slot[LAYERS];     // layer sitting at each depth
    int        top;
    rsp_item_t pending[$];
    int        n_errors;
    int        n_checked;
    int        n_cmds;
    int        n_mode[4];
    int        n_full;
    int        n_unalloc;
    int        peak_top;

    function new();
      for (int i = 0; i < LAYERS; i++) begin
        in_use[i]   = 0;
        depth_of[i] = -1;
        slot[i]     = 0;
      end
      top       = -1;
      peak_top  = -1;
      n_errors  = 0;
      n_checked = 0;
      n_cmds    = 0;
      n_full    = 0;
      n_unalloc = 0;
      for (int m = 0; m < 4; m++) n_mode[m] = 0;
    endfunction

    function int occupancy();
      int n;
      n = 0;
      for (int i = 0; i < LAYERS; i++) n += int'(in_use[i]);
      return n;
    endfunction

    function void put_slot(int z, int l);
      if (z < 0 || z >= LAYERS) return;
      slot[z] = l;
      if (l < LAYERS) depth_of[l] = z;
    endfunction

    // Move one layer to a new depth; layers in between slide by one.
    function void move_layer(int l, int nz);
      int old;
      int hi;
      old = depth_of[l];
      // hidden layer may go one above the top, a visible one only to the top
      hi = (old >= 0) ? top : top + 1;
      if (nz > hi) nz = hi;
      if (nz < -1) nz = -1;
      if (nz == old) return;
      if (old < 0) begin
        // insert: open a slot at nz
        if (top + 1 >= LAYERS) return;
        for (int z = top; z >= nz; z--)
          if (z >= 0 && z < LAYERS) put_slot(z + 1, slot[z]);
        put_slot(nz, l);
        top++;
      end else if (nz < 0) begin
        // hide: close the gap left behind
        for (int z = old; z < top; z++)
          if (z + 1 < LAYERS) put_slot(z, slot[z + 1]);
        depth_of[l] = -1;
        top--;
      end else if (old > nz) begin
        for (int z = old; z > nz; z--)
          if (z - 1 >= 0) put_slot(z, slot[z - 1]);
        put_slot(nz, l);
      end else begin
        for (int z = old; z < nz; z++)
          if (z + 1 < LAYERS) put_slot(z, slot[z + 1]);
        put_slot(nz, l);
      end
    endfunction

    // Called on every accepted command item.
    function void accept_cmd(logic [MODE_W-1:0] m, logic [LIDX_W-1:0] idx,
                             logic signed [TGT_W-1:0] tgt);
      rsp_item_t e;
      int        l;
      int        d;
      l = int'(idx);
      e.status = ST_OK;
      e.layer  = idx;
      d        = -1;
      n_cmds++;
      n_mode[m]++;
      case (m)
        MODE_ALLOC: begin
          e.status = ST_FULL;
          e.layer  = '0;
          for (int i = 0; i < LAYERS; i++) begin
            if (!in_use[i]) begin
              in_use[i]   = 1;
              depth_of[i] = -1;
              e.status    = ST_OK;
              e.layer     = LIDX_W'(i);
              break;
            end
          end
          if (e.status == ST_FULL) n_full++;
        end
        MODE_SET, MODE_FREE: begin
          if (!in_use[l]) begin
            e.status = ST_UNALLOC;
            n_unalloc++;
          end else if (m == MODE_SET) begin
            move_layer(l, int'(tgt));
            d = depth_of[l];
          end else begin
            if (depth_of[l] >= 0) move_layer(l, -1);
            in_use[l] = 0;
          end
        end
        default: begin
          // no-op reports the addressed layer as it stands
          d = depth_of[l];
        end
      endcase
      e.depth = DEP_W'(d);
      e.top   = DEP_W'(top);
      if (top > peak_top) peak_top = top;
      pending.push_back(e);
    endfunction

    // Called on every accepted response item.
    function void check_rsp(logic [STAT_W-1:0] st, logic [LIDX_W-1:0] lo,
                            logic signed [DEP_W-1:0] d, logic signed [DEP_W-1:0] t);
      rsp_item_t e;
      n_checked++;
      if (pending.size() == 0) begin
        n_errors++;
        if (n_errors <= MAX_SHOWN)
          $display("[%0t] response with nothing outstanding: st=%0d layer=%0d %s%0d top=%0d",
                   $time, st, lo, "depth=", d, t);
        return;
      end
      e = pending.pop_front();
      if (e.status !== st || e.layer !== lo || e.depth !== d || e.top !== t) begin
        n_errors++;
        if (n_errors <= MAX_SHOWN) begin
          $display("[%0t] mismatch #%0d: exp st=%0d layer=%0d depth=%0d top=%0d",
                   $time, n_checked, e.status, e.layer, e.depth, e.top);
          $display("    got st=%0d layer=%0d depth=%0d top=%0d", st, lo, d, t);
        end
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  int   cycles;

  lzom_cmd_if cmd_ch ();
  lzom_rsp_if rsp_ch ();

  zorder_tracker sb;

  layer_z_order_manager_unit #(
    .LAYERS(LAYERS)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .cmd(cmd_ch),
    .rsp(rsp_ch)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // known values on every input from time zero
  initial begin
    sb                  = new();
    rst                 = 1'b1;
    cmd_ch.valid        = 1'b0;
    cmd_ch.mode         = MODE_NOP;
    cmd_ch.layer_index  = '0;
    cmd_ch.target_depth = '0;
    rsp_ch.ready        = 1'b0;
  end

  // run watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYC_LIMIT) begin
      $display("timeout after %0d cycles, %0d responses outstanding",
               cycles, sb.pending.size());
      $display("FAILED: results differ");
      $finish;
    end
  end
  initial cycles = 0;

  // Response side: sampled at the rising edge, before the block's own updates land.
  always @(posedge clk) begin
    if (!rst && rsp_ch.valid && rsp_ch.ready)
      sb.check_rsp(rsp_ch.status, rsp_ch.layer_out, rsp_ch.depth_out, rsp_ch.top_out);
  end

  // Receiver stall pattern: segments with their own stall rate, and two long
  // hold-offs so the output register fills and the command side backs up.
  initial begin
    int seg_len;
    int rate;
    int next_hold;
    int n_holds;
    next_hold = 300;
    n_holds   = 0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      seg_len = $urandom_range(20, 200);
      case ($urandom_range(0, 3))
        0: rate = 0;
        1: rate = 25;
        2: rate = 50;
        default: rate = 90;
      endcase
      for (int c = 0; c < seg_len; c++) begin
        @(negedge clk);
        if (n_holds < 2 && sb.n_checked >= next_hold) begin
          rsp_ch.ready = 1'b0;
          for (int h = 0; h < 400; h++) @(negedge clk);
          n_holds++;
          next_hold = 1200;
        end
        rsp_ch.ready = ($urandom_range(0, 99) >= rate);
      end
    end
  end

  // Drive one command item and hold it until the block takes it.
  // valid stays high afterwards; the next call or an idle stretch changes it.
  task automatic send_cmd(input logic [MODE_W-1:0] m, input logic [LIDX_W-1:0] idx,
                          input logic signed [TGT_W-1:0] tgt);
    @(negedge clk);
    cmd_ch.valid        = 1'b1;
    cmd_ch.mode         = m;
    cmd_ch.layer_index  = idx;
    cmd_ch.target_depth = tgt;
    do @(posedge clk); while (!cmd_ch.ready);
    sb.accept_cmd(m, idx, tgt);
  endtask

  task automatic idle_cmd(input int n);
    @(negedge clk);
    cmd_ch.valid = 1'b0;
    for (int i = 1; i < n; i++) @(negedge clk);
  endtask

  // Pick one command, steering pool occupancy toward want_occ. Most items are
  // well-formed set-depth moves on allocated layers; some are pure noise.
  task automatic random_cmd(input int want_occ);
    int                      occ;
    int                      r;
    int                      l;
    int                      owned[$];
    logic [MODE_W-1:0]       m;
    logic signed [TGT_W-1:0] tgt;
    occ = sb.occupancy();
    r   = $urandom_range(0, 99);
    for (int i = 0; i < LAYERS; i++) if (sb.in_use[i]) owned.push_back(i);
    if (r < 8 || occ == 0) begin
      m   = (occ == 0 && r >= 8) ? MODE_ALLOC : MODE_W'($urandom_range(0, 3));
      l   = $urandom_range(0, LAYERS - 1);
      tgt = TGT_W'($urandom_range(0, 63));
      send_cmd(m, LIDX_W'(l), tgt);
      return;
    end
    r = $urandom_range(0, 99);
    if (occ < want_occ)      m = (r < 45) ? MODE_ALLOC : MODE_SET;
    else if (occ > want_occ) m = (r < 35) ? MODE_FREE : MODE_SET;
    else                     m = (r < 5) ? MODE_ALLOC : (r < 10) ? MODE_FREE : MODE_SET;
    l = owned[$urandom_range(0, owned.size() - 1)];
    r = $urandom_range(0, 99);
    if (r < 70)      tgt = TGT_W'(int'($urandom_range(0, sb.top + 2)) - 1);
    else if (r < 80) tgt = TGT_W'(sb.depth_of[l]);
    else             tgt = TGT_W'($urandom_range(0, 63));
    send_cmd(m, (m == MODE_ALLOC) ? LIDX_W'($urandom_range(0, LAYERS - 1)) : LIDX_W'(l),
             tgt);
  endtask

  initial begin
    int burst;
    int want_occ;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // ---- directed part ----
    send_cmd(MODE_NOP, 4'd0, 6'sd0);       // empty pool, nothing visible
    send_cmd(MODE_FREE, 4'd5, 6'sd0);      // free a layer never allocated
    send_cmd(MODE_SET, 4'd3, 6'sd0);       // set-depth on unallocated layer
    send_cmd(MODE_ALLOC, 4'd9, 6'sd0);     // lowest free: layer 0
    send_cmd(MODE_ALLOC, 4'd0, 6'sd0);
    send_cmd(MODE_ALLOC, 4'd0, 6'sd0);
    send_cmd(MODE_SET, 4'd0, 6'sd31);      // clamped to top+1 on empty stack
    send_cmd(MODE_SET, 4'd1, 6'sd0);       // insert at bottom, layer 0 slides up
    send_cmd(MODE_SET, 4'd2, -6'sd32);     // hidden stays hidden
    send_cmd(MODE_SET, 4'd2, 6'sd16);      // insert above all
    send_cmd(MODE_SET, 4'd2, 6'sd2);       // same depth, no change
    send_cmd(MODE_SET, 4'd2, 6'sd0);       // move down
    send_cmd(MODE_SET, 4'd2, 6'sd31);      // visible: clamped to top
    send_cmd(MODE_SET, 4'd0, -6'sd1);      // hide from the middle
    send_cmd(MODE_FREE, 4'd1, 6'sd0);      // free a visible layer
    send_cmd(MODE_FREE, 4'd0, 6'sd0);      // free a hidden layer
    send_cmd(MODE_NOP, 4'd15, -6'sd32);
    for (int i = 0; i < LAYERS - 1; i++)
      send_cmd(MODE_ALLOC, 4'd0, 6'sd0);   // fill the pool
    send_cmd(MODE_ALLOC, 4'd15, 6'sd31);   // pool full
    send_cmd(MODE_SET, 4'd15, 6'sd15);     // insert into populated stack

    // ---- random part: bursts with random gaps ----
    burst    = 0;
    want_occ = LAYERS;
    for (int n = 0; n < N_RANDOM; n++) begin
      if (n % 150 == 0) want_occ = $urandom_range(1, LAYERS);
      if (burst == 0) begin
        burst = $urandom_range(1, 40);
        idle_cmd($urandom_range(1, 8));
      end
      random_cmd(want_occ);
      burst--;
    end
    idle_cmd(1);

    // ---- drain ----
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);
    if (sb.pending.size() != 0) sb.n_errors++;

    $display("covered %0d commands: %0d alloc, %0d set-depth, %0d free, %0d no-op",
             sb.n_cmds, sb.n_mode[MODE_ALLOC], sb.n_mode[MODE_SET], sb.n_mode[MODE_FREE],
             sb.n_mode[MODE_NOP]);
    $display("%0d responses checked, %0d pool-full, %0d unallocated, peak top %0d, %0d errors",
             sb.n_checked, sb.n_full, sb.n_unalloc, sb.peak_top, sb.n_errors);
    if (sb.n_errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

### sim.f
hw/rtl/lzom_pkg.sv
hw/rtl/lzom_if.sv
hw/rtl/lzom_ram.sv
hw/rtl/layer_z_order_manager_unit.sv
tb/tb.sv
